>>> design/fcact_pkg.sv
// Shared types and constants of the four-channel advancing compare timer.
// Used by every module of the design; depends on nothing else.
package fcact_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int FLAG_BITS    = 5;
    localparam int STEP_BITS    = 16;
    localparam int DIV_BITS     = 17;
    localparam int PCOUNT_BITS  = 16;
    localparam int OUT_CNT_BITS = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 24;

    localparam logic [DIV_BITS-1:0]  PRESCALE_MAX = 17'd65536;
    localparam logic [STEP_BITS-1:0] STEP_RESET   = 16'hFFFF;

    localparam logic [CFG_IDX_BITS-1:0] REG_PRESCALE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_CH1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_CH2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_CH3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_CH4 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_IRQ_MASK = 3'd5;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [DIV_BITS-1:0]                    prescale_div;
        logic [MAX_CHANNELS-1:0][STEP_BITS-1:0] step;
        logic [FLAG_BITS-1:0]                   irq_mask;
    } t_cfg;

    typedef struct packed {
        logic                    irq;
        logic [FLAG_BITS-1:0]    status_flags;
        logic [OUT_CNT_BITS-1:0] count_value;
    } t_result;

endpackage

>>> design/four_channel_advancing_compare_timer.sv
// Top level of the four-channel advancing compare timer.
// Depends on fcact_pkg, fcact_cfg_regs, fcact_core and fcact_skid.
//
// Each request on the slave stream is either one input tick (tuser = 0) or a
// flag clear (tuser = 1, tdata holds the clear mask). Every request yields
// exactly one result on the master stream: the counter, the five status
// flags and the interrupt line after that request.
// Configuration registers are written over the cfg channel, which is always
// ready; index 0 is the prescaler, 1 to 4 the channel steps, 5 the interrupt
// enables. Write them only while no request is in flight.
// A request is taken in every cycle in which tready is high.
// The timer state is updated in the same cycle a request is taken, and the
// result goes into an output register backed by one skid entry, so the
// slave stays ready for one more request while a result waits.
// If the receiver stalls for longer, tready drops until the skid entry
// drains.
// Reset clears the prescaler and main counter, the flags, and sets all
// compare values and steps to 0xFFFF, the divisor to 1, the enables to 0.
module four_channel_advancing_compare_timer
    import fcact_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_BITS   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [DIV_BITS-1:0]       i_cfg_data,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,  // [4:0] clear_mask
    input  logic                      i_s_axis_tuser,  // [0] cmd
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata   // [15:0] count_value,
                                                       // [20:16] status_flags,
                                                       // [21] irq
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    push;

    fcact_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    assign push = i_s_axis_tvalid && o_s_axis_tready;

    fcact_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .i_cmd        (i_s_axis_tuser),
        .i_clear_mask (i_s_axis_tdata[FLAG_BITS-1:0]),
        .o_result     (core_result)
    );

    fcact_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (core_result),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_result)
    );

    assign o_m_axis_tdata = {2'b00, out_result};

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("Slave side stalled with no result pending.");

    a_irq_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_result.irq == |(out_result.status_flags & cfg.irq_mask)))
        else $error("Interrupt line disagrees with the enabled flags.");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("Streams not idle after reset.");

endmodule

>>> design/fcact_cfg_regs.sv
// Configuration register file of the compare timer.
// Depends on fcact_pkg for register indexes and the t_cfg type.
module fcact_cfg_regs
    import fcact_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIV_BITS-1:0]     i_cfg_data,
    output logic                    o_cfg_ready,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_div <= DIV_BITS'(1);
            r_cfg.step         <= {MAX_CHANNELS{STEP_RESET}};
            r_cfg.irq_mask     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PRESCALE: r_cfg.prescale_div <= i_cfg_data;
                REG_STEP_CH1: r_cfg.step[0]      <= i_cfg_data[STEP_BITS-1:0];
                REG_STEP_CH2: r_cfg.step[1]      <= i_cfg_data[STEP_BITS-1:0];
                REG_STEP_CH3: r_cfg.step[2]      <= i_cfg_data[STEP_BITS-1:0];
                REG_STEP_CH4: r_cfg.step[3]      <= i_cfg_data[STEP_BITS-1:0];
                REG_IRQ_MASK: r_cfg.irq_mask     <= i_cfg_data[FLAG_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> design/fcact_core.sv
// Prescaler, main counter, compare channels and status flags of the timer.
// Depends on fcact_pkg; updates its state once per accepted request.
module fcact_core
    import fcact_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_push,
    input  logic                 i_cmd,
    input  logic [FLAG_BITS-1:0] i_clear_mask,
    output t_result              o_result
);

    localparam logic [COUNT_BITS-1:0] CMP_RESET = COUNT_BITS'(STEP_RESET);

    logic [PCOUNT_BITS-1:0] r_pcount, n_pcount;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [FLAG_BITS-1:0]   r_flags, n_flags;
    logic [COUNT_BITS-1:0]  r_cmp [MAX_CHANNELS];
    logic [COUNT_BITS-1:0]  n_cmp [MAX_CHANNELS];

    logic [PCOUNT_BITS-1:0] last;
    logic                   tick;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [FLAG_BITS-1:0]   set_flags;

    always_comb begin
        if (i_cfg.prescale_div == '0) begin
            last = '0;
        end else if (i_cfg.prescale_div > PRESCALE_MAX) begin
            last = '1;
        end else begin
            last = PCOUNT_BITS'(i_cfg.prescale_div - DIV_BITS'(1));
        end
    end

    assign tick    = (i_cmd == CMD_TICK) && (r_pcount >= last);
    assign cnt_inc = r_count + COUNT_BITS'(1);

    assign set_flags[0] = tick && (cnt_inc == '0);

    for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_ch
        logic hit;
        assign hit = (ch < NUM_CHANNELS) && tick && (cnt_inc == r_cmp[ch]);
        assign set_flags[ch+1] = hit;
        assign n_cmp[ch] = hit ? r_cmp[ch] + COUNT_BITS'(i_cfg.step[ch]) : r_cmp[ch];
    end

    always_comb begin
        if (i_cmd == CMD_CLEAR) begin
            n_pcount = r_pcount;
            n_count  = r_count;
            n_flags  = r_flags & ~i_clear_mask;
        end else begin
            n_pcount = tick ? '0 : r_pcount + PCOUNT_BITS'(1);
            n_count  = tick ? cnt_inc : r_count;
            n_flags  = r_flags | set_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            r_count  <= '0;
            r_flags  <= '0;
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                r_cmp[ch] <= CMP_RESET;
            end
        end else if (i_push) begin
            r_pcount <= n_pcount;
            r_count  <= n_count;
            r_flags  <= n_flags;
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                r_cmp[ch] <= n_cmp[ch];
            end
        end
    end

    assign o_result.count_value  = OUT_CNT_BITS'(n_count);
    assign o_result.status_flags = n_flags;
    assign o_result.irq          = |(n_flags & i_cfg.irq_mask);

endmodule

>>> design/fcact_skid.sv
// Output register with a skid stage for the timer results.
// Depends on fcact_pkg for the t_result type.
module fcact_skid
    import fcact_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    push;

    assign o_ready = !r_skid_valid;
    assign push    = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (push) begin
            r_skid_data <= i_data;
        end
    end

endmodule
